// ===== design/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the compositor RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define AST_IMPL(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define AST_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition");
`else
`define AST_IMPL(label, clk, rst_n, prop)
`define AST_NEVER(label, clk, rst_n, cond)
`endif
`endif

// ===== design/afc_pkg.sv =====
// ---------------------------------------------------------------------------
// Compositor package
// Sizes, action codes and the blend helper shared by the compositor files.
// ---------------------------------------------------------------------------
package afc_pkg;
  localparam int MaxWidth = 256;
  localparam int MaxHeight = 256;
  localparam int XW = $clog2(MaxWidth);
  localparam int YW = $clog2(MaxHeight);
  localparam int AW = XW + YW;
  localparam int Depth = MaxWidth * MaxHeight;
  localparam int SW = $clog2(MaxWidth + 1);

  typedef enum logic [1:0] {
    ACT_BEGIN = 2'd0,
    ACT_PIXEL = 2'd1,
    ACT_END   = 2'd2,
    ACT_READ  = 2'd3
  } action_t;

  localparam logic [2:0] DISP_CLEAR   = 3'd2;
  localparam logic [2:0] DISP_RESTORE = 3'd3;

  // One channel: s + d*(255-a)/255, truncated. d*inv <= 65025, so the
  // division by 255 uses the reciprocal 257/65536 with a single correction.
  function automatic logic [7:0] blend_ch(input logic [7:0] s, input logic [7:0] d,
                                          input logic [7:0] inv);
    logic [15:0] p;
    logic [24:0] m;
    logic [8:0]  q;
    logic [16:0] r;
    p = d * inv;
    m = {9'd0, p} * 25'd257;
    q = m[24:16];
    r = {1'b0, p} - 17'(q) * 17'd255;
    if (r >= 17'd255) q = q + 9'd1;
    return 8'(s + q[7:0]);
  endfunction
endpackage

// ===== design/animated_frame_compositor_top.sv =====
// ---------------------------------------------------------------------------
// Animated frame compositor
// Draws frames onto a canvas RAM with GIF-style disposal and save/restore.
// ---------------------------------------------------------------------------
// A read or pixel item passes through S_RD and S_WB and gives its result in S_OUT;
// begin and end without a sweep go straight to S_OUT.
// One item at a time: a read or pixel does a canvas RAM read-modify-write, and
// the next item is taken only once the result has been taken. A save or
// restore sweep walks all 65536 entries one per cycle, a clear the rectangle.
// Reset: after reset a clearing pass zeroes all 65536 canvas entries; no item is accepted during it.
`include "assert_macros.svh"
module animated_frame_compositor_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [8:0]  cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  // tuser: action[1:0]
  input  logic [1:0]  in_tuser,
  // tdata: pos_x, pos_y, frame_width, frame_height, disposal, delay_ms,
  // pix_blue, pix_green, pix_red, pix_alpha (from bit 0 up), zero to 120 bits
  input  logic [119:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // tdata: out_blue, out_green, out_red, out_alpha, shown_delay_ms, zero to 56
  output logic [55:0] out_tdata
);
  typedef enum logic [2:0] {S_INIT, S_IDLE, S_RD, S_WB, S_SWEEP, S_OUT} st_t;
  typedef enum logic [1:0] {SW_SAVE, SW_RESTORE, SW_CLEAR} sweep_t;

  st_t st_r;
  sweep_t swk_r;
  logic [8:0] cw_r, ch_r;
  logic [7:0] left_r, top_r;
  logic [15:0] fw_r, fh_r, col_r, row_r;
  logic [2:0] disp_r;
  logic [1:0] act_r;
  logic [119:0] d_r;
  logic [afc_pkg::AW-1:0] addr_r, waddr_r;
  logic [afc_pkg::XW:0] sx_r, sx0_r, sxe_r;
  logic [afc_pkg::YW:0] sy_r, sye_r;
  logic rvalid_r, hit_r, ok_r;
  logic [55:0] res_r;

  logic [afc_pkg::SW-1:0] aw, ah;
  assign aw = (cw_r > 9'(afc_pkg::MaxWidth)) ? afc_pkg::SW'(afc_pkg::MaxWidth)
                                             : afc_pkg::SW'(cw_r);
  assign ah = (ch_r > 9'(afc_pkg::MaxHeight)) ? afc_pkg::SW'(afc_pkg::MaxHeight)
                                              : afc_pkg::SW'(ch_r);

  logic [15:0] px, py, fw, fh;
  logic [2:0] dsp;
  logic [19:0] dly;
  assign px = in_tdata[15:0];
  assign py = in_tdata[31:16];
  assign fw = in_tdata[47:32];
  assign fh = in_tdata[63:48];
  assign dsp = in_tdata[66:64];
  assign dly = in_tdata[86:67];

  // Canvas and saved RAM ports.
  logic c_we, s_we;
  logic [afc_pkg::AW-1:0] c_wa, c_ra, s_wa, s_ra;
  logic [31:0] c_wd, c_rd, s_rd;
  afc_ram #(.W(32), .D(afc_pkg::Depth)) u_canvas (
    .clk(clk), .we(c_we), .waddr(c_wa), .wdata(c_wd), .raddr(c_ra), .rdata(c_rd));
  afc_ram #(.W(32), .D(afc_pkg::Depth)) u_saved (
    .clk(clk), .we(s_we), .waddr(s_wa), .wdata(c_rd), .raddr(s_ra), .rdata(s_rd));

  assign in_tready = (st_r == S_IDLE);
  assign out_tvalid = (st_r == S_OUT);
  assign out_tdata = res_r;

  // Pixel write-back value.
  logic [31:0] src, blended;
  logic [7:0] inv;
  assign src = d_r[118:87];
  assign inv = 8'd255 - src[31:24];
  always_comb begin
    if (src[31:24] == 8'hFF) blended = src;
    else if (src[31:24] == 8'd0) blended = c_rd;
    else begin
      for (int k = 0; k < 4; k++)
        blended[8*k +: 8] = afc_pkg::blend_ch(src[8*k +: 8], c_rd[8*k +: 8], inv);
    end
  end

  // Address of the current sweep position.
  logic [afc_pkg::AW-1:0] swa;
  assign swa = {sy_r[afc_pkg::YW-1:0], sx_r[afc_pkg::XW-1:0]};

  always_comb begin
    c_we = 1'b0; c_wa = waddr_r; c_wd = 32'd0; c_ra = addr_r;
    s_we = 1'b0; s_wa = waddr_r; s_ra = swa;
    case (st_r)
      S_INIT: begin c_we = 1'b1; c_wa = swa; end
      S_WB: begin c_we = hit_r && (act_r == afc_pkg::ACT_PIXEL); c_wd = blended; end
      S_SWEEP: begin
        c_ra = swa;
        // Save: read canvas, write saved in the next cycle at the old address.
        s_we = (swk_r == SW_SAVE) && rvalid_r;
        c_we = ((swk_r == SW_RESTORE) && rvalid_r) || (swk_r == SW_CLEAR && ok_r);
        c_wa = (swk_r == SW_CLEAR) ? swa : waddr_r;
        c_wd = (swk_r == SW_RESTORE) ? s_rd : 32'd0;
      end
      default: ;
    endcase
  end

  logic last_sweep;
  assign last_sweep = (sx_r == sxe_r) && (sy_r == sye_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_INIT; sx_r <= '0; sy_r <= '0; cw_r <= 9'd256; ch_r <= 9'd256;
      fw_r <= '0; fh_r <= '0; disp_r <= '0; col_r <= '0; row_r <= '0;
      left_r <= '0; top_r <= '0; rvalid_r <= 1'b0; ok_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == 1'b0) cw_r <= cfg_data; else ch_r <= cfg_data;
      end
      unique case (st_r)
        S_INIT: begin
          sx_r <= sx_r + 1'b1;
          if (sx_r == afc_pkg::XW'(afc_pkg::MaxWidth - 1) + (afc_pkg::XW+1)'(0)) begin
            sx_r <= '0; sy_r <= sy_r + 1'b1;
            if (sy_r == (afc_pkg::YW+1)'(afc_pkg::MaxHeight - 1)) begin
              sy_r <= '0; st_r <= S_IDLE;
            end
          end
        end
        S_IDLE: if (in_tvalid) begin
          act_r <= in_tuser; d_r <= in_tdata; res_r <= '0; hit_r <= 1'b0;
          unique case (afc_pkg::action_t'(in_tuser))
            afc_pkg::ACT_BEGIN: begin
              if ({8'd0, aw} <= px || {8'd0, ah} <= py) begin
                left_r <= '0; top_r <= '0;
              end else begin
                left_r <= px[7:0]; top_r <= py[7:0];
              end
              fw_r <= fw; fh_r <= fh; disp_r <= dsp; col_r <= '0; row_r <= '0;
              res_r[51:32] <= (dly < 20'd20) ? 20'd100 : dly;
              if (dsp == afc_pkg::DISP_RESTORE) begin
                swk_r <= SW_SAVE; sx_r <= '0; sy_r <= '0; rvalid_r <= 1'b0;
                sxe_r <= (afc_pkg::XW+1)'(afc_pkg::MaxWidth - 1);
                sye_r <= (afc_pkg::YW+1)'(afc_pkg::MaxHeight - 1);
                st_r <= S_SWEEP;
              end else st_r <= S_OUT;
            end
            afc_pkg::ACT_PIXEL: begin
              if (fw_r != 0 && row_r < fh_r) begin
                logic [16:0] x, y;
                x = 17'(left_r) + 17'(col_r);
                y = 17'(top_r) + 17'(row_r);
                hit_r <= (x < 17'(aw)) && (y < 17'(ah));
                addr_r <= {y[afc_pkg::YW-1:0], x[afc_pkg::XW-1:0]};
                waddr_r <= {y[afc_pkg::YW-1:0], x[afc_pkg::XW-1:0]};
                if (col_r + 16'd1 >= fw_r) begin
                  col_r <= '0; row_r <= row_r + 16'd1;
                end else col_r <= col_r + 16'd1;
              end
              st_r <= S_RD;
            end
            afc_pkg::ACT_END: begin
              fw_r <= '0; fh_r <= '0; disp_r <= '0; col_r <= '0; row_r <= '0;
              sx_r <= '0; sy_r <= '0; rvalid_r <= 1'b0;
              sxe_r <= (afc_pkg::XW+1)'(afc_pkg::MaxWidth - 1);
              sye_r <= (afc_pkg::YW+1)'(afc_pkg::MaxHeight - 1);
              st_r <= S_OUT;
              if (disp_r == afc_pkg::DISP_RESTORE) begin
                swk_r <= SW_RESTORE; st_r <= S_SWEEP;
              end else if (disp_r == afc_pkg::DISP_CLEAR) begin
                logic [16:0] r, b;
                r = 17'(left_r) + 17'(fw_r);
                b = 17'(top_r) + 17'(fh_r);
                if (r > 17'(aw)) r = 17'(aw);
                if (b > 17'(ah)) b = 17'(ah);
                if (r > 17'(left_r) && b > 17'(top_r)) begin
                  swk_r <= SW_CLEAR; ok_r <= 1'b1; st_r <= S_SWEEP;
                  sx_r <= (afc_pkg::XW+1)'(left_r); sx0_r <= (afc_pkg::XW+1)'(left_r);
                  sy_r <= (afc_pkg::YW+1)'(top_r);
                  sxe_r <= (afc_pkg::XW+1)'(r - 17'd1);
                  sye_r <= (afc_pkg::YW+1)'(b - 17'd1);
                end
              end
            end
            default: begin
              addr_r <= {py[afc_pkg::YW-1:0], px[afc_pkg::XW-1:0]};
              hit_r <= (px < 16'(aw)) && (py < 16'(ah));
              st_r <= S_RD;
            end
          endcase
        end
        // The canvas word shows up on the read port in S_WB, the state after S_RD.
        S_RD: st_r <= S_WB;
        S_WB: begin
          st_r <= S_OUT;
        end
        S_SWEEP: begin
          rvalid_r <= ok_r ? 1'b0 : 1'b1;
          waddr_r <= swa;
          if (rvalid_r && waddr_r == {afc_pkg::YW'(sye_r), afc_pkg::XW'(sxe_r)}
              && swk_r != SW_CLEAR) begin
            st_r <= S_OUT;
          end else if (ok_r && last_sweep) begin
            ok_r <= 1'b0; st_r <= S_OUT;
          end else if (!(last_sweep && swk_r != SW_CLEAR && rvalid_r)) begin
            if (!last_sweep) begin
              if (sx_r == sxe_r) begin
                sx_r <= (swk_r == SW_CLEAR) ? sx0_r : '0;
                sy_r <= sy_r + 1'b1;
              end else sx_r <= sx_r + 1'b1;
            end
          end
        end
        S_OUT: if (out_tready) st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
      if (st_r == S_WB && act_r == afc_pkg::ACT_READ && hit_r) res_r[31:0] <= c_rd;
    end
  end

  `AST_NEVER(a_ready_and_valid, clk, rst_n, in_tready && out_tvalid)
  `AST_IMPL(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
  `AST_IMPL(a_clear_bounds, clk, rst_n, (st_r == S_SWEEP && swk_r == SW_CLEAR) |-> (sx_r <= sxe_r && sy_r <= sye_r))
endmodule

// ===== design/afc_ram.sv =====
// ---------------------------------------------------------------------------
// Generic RAM
// Single write port, single registered read port.
// ---------------------------------------------------------------------------
module afc_ram #(
  parameter int W = 32,
  parameter int D = 65536
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);
  logic [W-1:0] mem [D];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Compositor testbench
// Streams begin, pixel, end and read items into the frame compositor,
// predicts results from a private canvas model or the directed table, and checks each one.
// ---------------------------------------------------------------------------
module testbench;
  localparam logic REG_CANVAS_W = 1'b0;
  localparam logic REG_CANVAS_H = 1'b1;
  localparam int   STALL_LIMIT  = 400000;
  localparam int   PHASE_ITEMS  = 100;

  typedef struct packed {
    logic [7:0]  alpha;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [19:0] delay;
    logic [2:0]  disp;
    logic [15:0] fh;
    logic [15:0] fw;
    logic [15:0] py;
    logic [15:0] px;
  } frame_item_t;

  typedef struct packed {
    logic [19:0] delay;
    logic [31:0] pixel;
  } canvas_result_t;

  typedef struct {
    afc_pkg::action_t act;
    frame_item_t      fields;
    bit               typed;
    canvas_result_t   want;
  } table_row_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_we = 1'b0;
  logic [0:0]   cfg_index = '0;
  logic [8:0]   cfg_data = '0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [1:0]   in_tuser = '0;
  logic [119:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [55:0]  out_tdata;

  always #5 clk = ~clk;

  animated_frame_compositor_top u_top (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tuser(in_tuser), .in_tdata(in_tdata), .out_tvalid(out_tvalid),
    .out_tready(out_tready), .out_tdata(out_tdata)
  );

  // Private copy of the compositor state.
  logic [31:0] canvas_px [afc_pkg::Depth];
  logic [31:0] saved_px [afc_pkg::Depth];
  int unsigned reg_w, reg_h;
  int unsigned frm_left, frm_top, frm_w, frm_h, frm_disp, col, row;

  canvas_result_t pending_results[$];
  int errors = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int save_budget = 3;
  int quiet_cycles = 0;

  function automatic logic [7:0] mix_channel(int unsigned s, int unsigned d, int unsigned inv);
    return 8'((s + d * inv / 255) & 8'hFF);
  endfunction

  function automatic logic [31:0] composite(logic [31:0] dst, logic [31:0] src);
    logic [31:0] res;
    int unsigned a;
    a = src[31:24];
    if (a == 255) return src;
    if (a == 0) return dst;
    for (int sh = 0; sh < 32; sh += 8)
      res[sh +: 8] = mix_channel(src[sh +: 8], dst[sh +: 8], 255 - a);
    return res;
  endfunction

  // Applies one accepted item to the canvas model and returns its result.
  function automatic canvas_result_t composite_step(afc_pkg::action_t act, frame_item_t f);
    canvas_result_t r;
    int unsigned w, h, x, y, px, py, right, bottom;
    logic [31:0] src;
    r = '0;
    w = reg_w > afc_pkg::MaxWidth ? afc_pkg::MaxWidth : reg_w;
    h = reg_h > afc_pkg::MaxHeight ? afc_pkg::MaxHeight : reg_h;
    px = f.px;
    py = f.py;
    src = {f.alpha, f.red, f.green, f.blue};
    case (act)
      afc_pkg::ACT_BEGIN: begin
        if (px >= w || py >= h) begin
          px = 0;
          py = 0;
        end
        frm_left = px & 8'hFF;
        frm_top = py & 8'hFF;
        frm_w = f.fw;
        frm_h = f.fh;
        frm_disp = f.disp;
        col = 0;
        row = 0;
        if (f.disp == afc_pkg::DISP_RESTORE) saved_px = canvas_px;
        r.delay = f.delay < 20 ? 20'd100 : f.delay;
      end
      afc_pkg::ACT_PIXEL: begin
        if (frm_w != 0 && row < frm_h) begin
          x = frm_left + col;
          y = frm_top + row;
          if (x < w && y < h)
            canvas_px[y * afc_pkg::MaxWidth + x] =
              composite(canvas_px[y * afc_pkg::MaxWidth + x], src);
          col++;
          if (col >= frm_w) begin
            col = 0;
            row++;
          end
        end
      end
      afc_pkg::ACT_END: begin
        if (frm_disp == afc_pkg::DISP_CLEAR) begin
          right = frm_left + frm_w;
          bottom = frm_top + frm_h;
          if (right > w) right = w;
          if (bottom > h) bottom = h;
          for (y = frm_top; y < bottom; y++)
            for (x = frm_left; x < right; x++) canvas_px[y * afc_pkg::MaxWidth + x] = '0;
        end else if (frm_disp == afc_pkg::DISP_RESTORE) begin
          canvas_px = saved_px;
        end
        frm_w = 0;
        frm_h = 0;
        frm_disp = 0;
        col = 0;
        row = 0;
      end
      default: begin
        if (px < w && py < h) r.pixel = canvas_px[py * afc_pkg::MaxWidth + px];
      end
    endcase
    return r;
  endfunction

  // Drives one item, with an optional idle gap first, and waits until it is
  // taken. The valid stays high afterwards so back-to-back items need no
  // second assignment in the same step.
  task automatic send_item(afc_pkg::action_t act, frame_item_t f, bit typed = 0,
                           canvas_result_t want = '0);
    canvas_result_t predicted;
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= act;
    in_tdata <= {1'b0, f};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted = composite_step(act, f);
    pending_results.insert(pending_results.size(), typed ? want : predicted);
  endtask

  // One register write, followed by a quiet cycle on the write port.
  task automatic write_reg(logic [0:0] idx, logic [8:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_CANVAS_W) reg_w = val;
    else reg_h = val;
    @(posedge clk);
  endtask

  // Pauses the sender until every expected result has come back.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic frame_item_t random_fields();
    frame_item_t f;
    logic [127:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom};
    f = raw[$bits(frame_item_t)-1:0];
    if (f.fw == 0) f.fw = 16'd1;
    if (f.fh == 0) f.fh = 16'd1;
    return f;
  endfunction

  function automatic frame_item_t random_pixel();
    frame_item_t f;
    f = random_fields();
    case ($urandom_range(3))
      0: f.alpha = 8'h00;
      1: f.alpha = 8'hFF;
      default: ;
    endcase
    return f;
  endfunction

  // One well-formed frame with random content, sometimes cut short or
  // followed by surplus pixels, with reads scattered around it.
  task automatic random_frame(ref int count);
    frame_item_t f;
    int unsigned w, h, npix;
    w = reg_w > afc_pkg::MaxWidth ? afc_pkg::MaxWidth : reg_w;
    h = reg_h > afc_pkg::MaxHeight ? afc_pkg::MaxHeight : reg_h;
    f = random_fields();
    f.fw = 16'($urandom_range(1, 6));
    f.fh = 16'($urandom_range(1, 4));
    if ($urandom_range(7) != 0) begin
      f.px = 16'($urandom_range(w - 1));
      f.py = 16'($urandom_range(h - 1));
    end
    if ($urandom_range(3) == 0) f.delay = 20'($urandom_range(25));
    f.disp = 3'($urandom_range(7));
    if (f.disp == afc_pkg::DISP_RESTORE && (save_budget == 0 || $urandom_range(3) != 0))
      f.disp = afc_pkg::DISP_CLEAR;
    if (f.disp == afc_pkg::DISP_RESTORE) save_budget--;
    send_item(afc_pkg::ACT_BEGIN, f);
    count++;
    npix = f.fw * f.fh;
    if ($urandom_range(7) == 0) npix = $urandom_range(npix);
    else npix += $urandom_range(1);
    repeat (npix) begin
      send_item(afc_pkg::ACT_PIXEL, random_pixel());
      count++;
    end
    repeat ($urandom_range(1, 3)) begin
      f = random_fields();
      f.px = 16'((f.px & 16'h7) + frm_left);
      f.py = 16'((f.py & 16'h3) + frm_top);
      send_item(afc_pkg::ACT_READ, f);
      count++;
    end
    send_item(afc_pkg::ACT_END, random_fields());
    f = random_fields();
    f.px = f.px & 16'hF;
    f.py = f.py & 16'hF;
    send_item(afc_pkg::ACT_READ, f);
    count += 2;
  endtask

  // Stray items: any action with random field values; a stray begin never asks for clear or restore disposal.
  task automatic random_noise(ref int count);
    frame_item_t f;
    afc_pkg::action_t act;
    f = random_fields();
    act = afc_pkg::action_t'($urandom_range(3));
    if (act == afc_pkg::ACT_BEGIN &&
        (f.disp == afc_pkg::DISP_CLEAR || f.disp == afc_pkg::DISP_RESTORE)) f.disp = '0;
    send_item(act, f);
    count++;
  endtask

  // Receiver side: random stalls driven at the clock edge.
  always @(posedge clk) out_tready <= ($urandom_range(99) >= stall_pct);

  // Result checker and watchdog.
  always @(posedge clk) begin
    canvas_result_t got, want;
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (out_tvalid && out_tready) begin
        got = {out_tdata[51:32], out_tdata[31:0]};
        if (pending_results.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result %h", got);
        end else begin
          want = pending_results.pop_front();
          if (got !== want || out_tdata[55:52] !== 4'd0) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: delay exp %0d got %0d, pixel exp %h got %h",
                       want.delay, got.delay, want.pixel, got.pixel);
          end
        end
      end
      if (quiet_cycles > STALL_LIMIT) begin
        $display("testbench: done, errors");
        $finish;
      end
    end
  end

  // Directed table: extremes, every action and the special cases.
  function automatic table_row_t row_of(afc_pkg::action_t act, int px, int py, int fw,
                                        int fh, int disp, int delay, logic [31:0] bgra,
                                        bit typed = 0, canvas_result_t want = '0);
    table_row_t r;
    r.act = act;
    r.fields = '{alpha: bgra[31:24], red: bgra[23:16], green: bgra[15:8],
                 blue: bgra[7:0], delay: 20'(delay), disp: 3'(disp), fh: 16'(fh),
                 fw: 16'(fw), py: 16'(py), px: 16'(px)};
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  table_row_t directed[$];

  initial begin
    int count;
    int unsigned cfg_w [4] = '{256, 1, 511, 8};
    int unsigned cfg_h [4] = '{256, 1, 300, 5};
    int idle_set [4] = '{0, 52, 0, 10};
    int stall_set [4] = '{0, 0, 52, 10};
    for (int i = 0; i < afc_pkg::Depth; i++) canvas_px[i] = '0;
    reg_w = 256;
    reg_h = 256;
    {frm_left, frm_top, frm_w, frm_h, frm_disp, col, row} = '0;

    // Reads straight after reset see a blank canvas; offsets out of range
    // snap to the corner; short delays become 100.
    directed = '{
      row_of(afc_pkg::ACT_READ, 0, 0, 1, 1, 0, 0, 0, 1, '0),
      row_of(afc_pkg::ACT_READ, 65535, 65535, 1, 1, 7, 1048575, 32'hFFFFFFFF, 1, '0),
      row_of(afc_pkg::ACT_BEGIN, 65535, 65535, 3, 2, 0, 0, 0, 1,
             '{delay: 20'd100, pixel: 32'd0}),
      row_of(afc_pkg::ACT_PIXEL, 0, 0, 1, 1, 0, 0, 32'hFF10_2030),
      row_of(afc_pkg::ACT_PIXEL, 0, 0, 1, 1, 0, 0, 32'h00FF_FFFF),
      row_of(afc_pkg::ACT_PIXEL, 0, 0, 1, 1, 0, 0, 32'h8040_4040),
      row_of(afc_pkg::ACT_PIXEL, 0, 0, 1, 1, 0, 0, 32'hFFFF_FFFF),
      row_of(afc_pkg::ACT_PIXEL, 0, 0, 1, 1, 0, 0, 32'h01FF_FFFF),
      row_of(afc_pkg::ACT_PIXEL, 0, 0, 1, 1, 0, 0, 32'h7F00_0000),
      row_of(afc_pkg::ACT_PIXEL, 0, 0, 1, 1, 0, 0, 32'hFF11_1111),
      row_of(afc_pkg::ACT_END, 0, 0, 1, 1, 0, 0, 0),
      row_of(afc_pkg::ACT_END, 0, 0, 1, 1, 0, 0, 0),
      row_of(afc_pkg::ACT_PIXEL, 0, 0, 1, 1, 0, 0, 32'hFF77_7777),
      row_of(afc_pkg::ACT_READ, 0, 1, 1, 1, 0, 0, 0),
      row_of(afc_pkg::ACT_READ, 2, 1, 1, 1, 0, 0, 0),
      row_of(afc_pkg::ACT_BEGIN, 254, 254, 4, 4, 2, 19, 0, 1,
             '{delay: 20'd100, pixel: 32'd0}),
      row_of(afc_pkg::ACT_PIXEL, 0, 0, 1, 1, 0, 0, 32'hFFAB_CDEF),
      row_of(afc_pkg::ACT_PIXEL, 0, 0, 1, 1, 0, 0, 32'hFF12_3456),
      row_of(afc_pkg::ACT_READ, 255, 254, 1, 1, 0, 0, 0),
      row_of(afc_pkg::ACT_END, 0, 0, 1, 1, 0, 0, 0),
      row_of(afc_pkg::ACT_READ, 254, 254, 1, 1, 0, 0, 0),
      row_of(afc_pkg::ACT_BEGIN, 1, 0, 65535, 65535, 3, 20, 0, 1,
             '{delay: 20'd20, pixel: 32'd0}),
      row_of(afc_pkg::ACT_PIXEL, 0, 0, 1, 1, 0, 0, 32'hFF00_FF00),
      row_of(afc_pkg::ACT_END, 0, 0, 1, 1, 0, 0, 0),
      row_of(afc_pkg::ACT_BEGIN, 3, 3, 1, 1, 4, 1048575, 0, 1,
             '{delay: 20'd1048575, pixel: 32'd0})
    };
    save_budget--;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int p = 0; p < 4; p++) begin
      // Registers change only while nothing is in flight.
      write_reg(REG_CANVAS_W, 9'(cfg_w[p]));
      write_reg(REG_CANVAS_H, 9'(cfg_h[p]));
      idle_pct = idle_set[p];
      stall_pct = stall_set[p];
      count = 0;
      if (p == 0) begin
        foreach (directed[i]) begin
          send_item(directed[i].act, directed[i].fields, directed[i].typed, directed[i].want);
          count++;
        end
        send_item(afc_pkg::ACT_END, random_fields());
      end
      while (count < PHASE_ITEMS) begin
        if ($urandom_range(4) == 0) random_noise(count);
        else random_frame(count);
        // The sender also holds off now and then until the block is empty.
        if ($urandom_range(9) == 0) drain();
      end
      drain();
    end

    if (errors == 0) $display("testbench: done, clean");
    else $display("testbench: done, errors");
    $finish;
  end
endmodule

// ===== animated_frame_compositor_top.f =====
+incdir+design
design/afc_pkg.sv
design/afc_ram.sv
design/animated_frame_compositor_top.sv
test/testbench.sv
